FILE: design/sopg_pkg.sv
package sopg_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

   localparam int ADDR_W  = 19;
   localparam int COORD_W = 12;
   localparam int EXT_W   = 10;
   localparam int SQ_W    = 2 * EXT_W;
   localparam int REM_W   = EXT_W + 3;
   localparam int CNT_W   = 4;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [2:0] KIND_SQUARE   = 3'd0;
   localparam logic [2:0] KIND_CROSS    = 3'd1;
   localparam logic [2:0] KIND_TRIANGLE = 3'd2;
   localparam logic [2:0] KIND_CIRCLE   = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   typedef struct packed {
      logic        operation;
      logic [2:0]  shape_kind;
      logic [9:0]  origin_x;
      logic [8:0]  origin_y;
      logic [9:0]  extent;
      logic [31:0] pen_color;
   } req_type;

   typedef struct packed {
      logic [18:0] pixel_address;
      logic [31:0] pixel_value;
      logic        off_screen;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic load;      // take a new shape from the request
      logic esq;       // square the radius
      logic snap;      // copy pending pixel into the emit register
      logic step;      // advance the shape sequencer once
      logic rmul;      // square the column offset, open the root
      logic riter;     // one root digit
      logic out_load;  // load the result register
   } cmd_type;

   typedef struct packed {
      logic yield;
      logic fin;
      logic need_root;
      logic root_last;
      logic pend_valid;
   } sts_type;

endpackage

FILE: design/sopg_ctrl.sv
module sopg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sopg_pkg::sts_type sts,
   output sopg_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_GEN   = 3'd2;
   localparam logic [2:0] ST_RMUL  = 3'd3;
   localparam logic [2:0] ST_RITER = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       tick_ff, tick_in;
   logic       valid_ff, valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      tick_in  = tick_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == sopg_pkg::OP_START) begin
                  cmd.load = 1'b1;
                  tick_in  = 1'b0;
                  state_in = ST_PREP;
               end else if (sts.pend_valid) begin
                  cmd.snap = 1'b1;
                  tick_in  = 1'b1;
                  state_in = ST_GEN;
               end
            end
         end
         ST_PREP: begin
            cmd.esq  = 1'b1;
            state_in = ST_GEN;
         end
         ST_GEN: begin
            if (sts.need_root) begin
               state_in = ST_RMUL;
            end else begin
               cmd.step = 1'b1;
               if (sts.yield || sts.fin) begin
                  state_in = tick_ff ? ST_OUT : ST_IDLE;
               end
            end
         end
         ST_RMUL: begin
            cmd.rmul = 1'b1;
            state_in = ST_RITER;
         end
         ST_RITER: begin
            cmd.riter = 1'b1;
            if (sts.root_last) begin
               state_in = ST_GEN;
            end
         end
         ST_OUT: begin
            // hold until the result register is free
            if (!valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: design/sopg_dpath.sv
module sopg_dpath (
   input  logic              clock,
   input  logic              reset,
   input  sopg_pkg::req_type req_item,
   input  sopg_pkg::cmd_type cmd,
   output sopg_pkg::sts_type sts,
   output sopg_pkg::rsp_type rsp_item
);

   localparam int CW = sopg_pkg::COORD_W;
   localparam int AW = sopg_pkg::ADDR_W;
   localparam int EW = sopg_pkg::EXT_W;
   localparam int SW = sopg_pkg::SQ_W;
   localparam int RW = sopg_pkg::REM_W;

   logic [2:0]          kind_ff;
   logic [9:0]          x_ff;
   logic [8:0]          y_ff;
   logic [EW-1:0]       e_ff;
   logic [31:0]         color_ff;
   logic                busy_ff, busy_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [1:0]          sub_ff, sub_in;
   logic signed [CW-1:0] fill_ff, fill_in, pl_ff, pl_in, pu_ff, pu_in;
   logic [EW-1:0]       root_ff;
   logic                exact_ff, root_ok_ff;
   logic [SW-1:0]       esq_ff, dx2_ff;
   logic [RW-1:0]       rem_ff;
   logic [sopg_pkg::CNT_W-1:0] rcnt_ff;
   logic [AW-1:0]       pend_addr_ff, emit_addr_ff;
   logic                pend_off_ff, emit_off_ff, pend_valid_ff, emit_last_ff;

   logic signed [CW-1:0] xs, ys, es, is, xc, lower, upper, ce, hi, px, py, dx;
   logic [EW-1:0]       adx;
   logic                yield, fin, need_root, direct, on;
   logic [AW-1:0]       addr;
   logic [SW-1:0]       nsq;
   logic [1:0]          pair;
   logic [RW-1:0]       remsh, trial, rem_nx;
   logic [EW-1:0]       root_nx;

   assign xs    = CW'(signed'({1'b0, x_ff}));
   assign ys    = CW'(signed'({1'b0, y_ff}));
   assign es    = CW'(signed'({1'b0, e_ff}));
   assign is    = signed'(idx_ff[CW-1:0]);
   assign xc    = xs - es + is;
   assign dx    = is - es;
   assign adx   = dx[CW-1] ? EW'(-dx) : EW'(dx);
   assign ce    = exact_ff ? CW'(root_ff) : CW'(root_ff) + CW'(1);
   assign lower = ys + CW'(root_ff);
   assign upper = ys - ce;

   always_comb begin
      sub_in    = sub_ff;
      idx_in    = idx_ff;
      fill_in   = fill_ff;
      pl_in     = pl_ff;
      pu_in     = pu_ff;
      busy_in   = busy_ff;
      yield     = 1'b0;
      fin       = 1'b0;
      need_root = 1'b0;
      direct    = 1'b0;
      px        = '0;
      py        = '0;
      hi        = '0;
      if (!busy_ff) begin
         fin = 1'b1;
      end else begin
         case (kind_ff)
            sopg_pkg::KIND_SQUARE: begin
               if (idx_ff >= AW'(e_ff)) begin
                  if (!sub_ff[1]) begin
                     sub_in = 2'd2;
                     idx_in = '0;
                  end else begin
                     busy_in = 1'b0;
                     fin     = 1'b1;
                  end
               end else begin
                  yield = 1'b1;
                  sub_in = sub_ff + 2'd1;
                  case (sub_ff)
                     2'd0: begin px = xs + is; py = ys; end
                     2'd1: begin
                        px = xs + is; py = ys + es - CW'(1);
                        sub_in = 2'd0; idx_in = idx_ff + AW'(1);
                     end
                     2'd2: begin px = xs; py = ys + is; end
                     default: begin
                        px = xs + es - CW'(1); py = ys + is;
                        sub_in = 2'd2; idx_in = idx_ff + AW'(1);
                     end
                  endcase
               end
            end
            sopg_pkg::KIND_CROSS: begin
               if (idx_ff >= AW'(e_ff)) begin
                  busy_in = 1'b0;
                  fin     = 1'b1;
               end else begin
                  yield = 1'b1;
                  py    = ys + is;
                  if (sub_ff == 2'd0) begin
                     px = xs + is; sub_in = 2'd1;
                  end else begin
                     px = xs + es - CW'(1) - is;
                     sub_in = 2'd0; idx_in = idx_ff + AW'(1);
                  end
               end
            end
            sopg_pkg::KIND_TRIANGLE: begin
               if (idx_ff >= AW'(e_ff)) begin
                  busy_in = 1'b0;
                  fin     = 1'b1;
               end else begin
                  yield  = 1'b1;
                  sub_in = sub_ff + 2'd1;
                  px     = sub_ff[0] ? xs + is : xs - is;
                  py     = sub_ff[1] ? ys + es - CW'(1) : ys + is;
                  if (sub_ff == 2'd3) begin
                     idx_in = idx_ff + AW'(1);
                  end
               end
            end
            sopg_pkg::KIND_CIRCLE: begin
               px = xc;
               if (idx_ff > AW'({e_ff, 1'b0})) begin
                  busy_in = 1'b0;
                  fin     = 1'b1;
               end else begin
                  case (sub_ff)
                     2'd0: begin
                        if (!root_ok_ff) begin
                           need_root = 1'b1;
                        end else begin
                           yield = 1'b1;
                           py    = lower;
                           pl_in = (idx_ff == '0) ? lower : pl_ff;
                           fill_in = (pl_in < lower) ? pl_in : lower;
                           sub_in = 2'd1;
                        end
                     end
                     2'd1: begin
                        hi = (pl_ff > lower) ? pl_ff : lower;
                        if (fill_ff < hi) begin
                           yield = 1'b1; py = fill_ff; fill_in = fill_ff + CW'(1);
                        end else begin
                           pl_in   = lower;
                           pu_in   = (idx_ff == '0) ? upper : pu_ff;
                           fill_in = (pu_in < upper) ? pu_in : upper;
                           sub_in  = 2'd2;
                        end
                     end
                     2'd2: begin
                        hi = (pu_ff > upper) ? pu_ff : upper;
                        if (fill_ff < hi) begin
                           yield = 1'b1; py = fill_ff; fill_in = fill_ff + CW'(1);
                        end else begin
                           pu_in  = upper;
                           sub_in = 2'd3;
                        end
                     end
                     default: begin
                        yield  = 1'b1;
                        py     = upper;
                        sub_in = 2'd0;
                        idx_in = idx_ff + AW'(1);
                     end
                  endcase
               end
            end
            sopg_pkg::KIND_CLEAR: begin
               if (idx_ff >= AW'(sopg_pkg::SCREEN_PIXELS)) begin
                  busy_in = 1'b0;
                  fin     = 1'b1;
               end else begin
                  yield  = 1'b1;
                  direct = 1'b1;
                  idx_in = idx_ff + AW'(1);
               end
            end
            default: begin
               busy_in = 1'b0;
               fin     = 1'b1;
            end
         endcase
      end
   end

   assign on = direct || (!px[CW-1] && px < CW'(sopg_pkg::SCREEN_WIDTH) &&
                          !py[CW-1] && py < CW'(sopg_pkg::SCREEN_HEIGHT));
   assign addr = direct ? idx_ff :
                 (!on ? '0 : AW'($unsigned(py)) * AW'(sopg_pkg::SCREEN_WIDTH)
                             + AW'($unsigned(px)));

   // one root digit per cycle, remainder kept for the exactness test
   assign nsq     = esq_ff - dx2_ff;
   assign pair    = 2'(nsq >> {rcnt_ff, 1'b0});
   assign remsh   = {rem_ff[RW-3:0], pair};
   assign trial   = RW'({root_ff, 2'b01});
   assign rem_nx  = (remsh >= trial) ? remsh - trial : remsh;
   assign root_nx = {root_ff[EW-2:0], (remsh >= trial)};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         root_ok_ff    <= 1'b0;
         kind_ff       <= '0;
         idx_ff        <= '0;
         sub_ff        <= '0;
         fill_ff       <= '0;
         pl_ff         <= '0;
         pu_ff         <= '0;
      end else if (cmd.load) begin
         kind_ff       <= req_item.shape_kind;
         busy_ff       <= (req_item.shape_kind <= sopg_pkg::KIND_CLEAR);
         pend_valid_ff <= 1'b0;
         root_ok_ff    <= 1'b0;
         idx_ff        <= '0;
         sub_ff        <= '0;
         fill_ff       <= '0;
         pl_ff         <= '0;
         pu_ff         <= '0;
      end else begin
         if (cmd.step) begin
            busy_ff <= busy_in;
            idx_ff  <= idx_in;
            sub_ff  <= sub_in;
            fill_ff <= fill_in;
            pl_ff   <= pl_in;
            pu_ff   <= pu_in;
            if (yield) begin
               pend_valid_ff <= 1'b1;
               if (sub_ff == 2'd0) begin
                  root_ok_ff <= 1'b0;
               end
            end else if (fin) begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (cmd.riter && rcnt_ff == '0) begin
            root_ok_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= req_item.origin_x;
         y_ff     <= req_item.origin_y;
         e_ff     <= req_item.extent;
         color_ff <= req_item.pen_color;
      end
      if (cmd.esq) begin
         esq_ff <= e_ff * e_ff;
      end
      if (cmd.rmul) begin
         dx2_ff  <= adx * adx;
         rcnt_ff <= sopg_pkg::CNT_W'(EW - 1);
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.riter) begin
         rem_ff   <= rem_nx;
         root_ff  <= root_nx;
         rcnt_ff  <= rcnt_ff - sopg_pkg::CNT_W'(1);
         exact_ff <= (rem_nx == '0);
      end
      if (cmd.step && yield) begin
         pend_addr_ff <= addr;
         pend_off_ff  <= !on;
      end
      if (cmd.snap) begin
         emit_addr_ff <= pend_addr_ff;
         emit_off_ff  <= pend_off_ff;
      end
      if (cmd.step) begin
         emit_last_ff <= fin;
      end
      if (cmd.out_load) begin
         rsp_item.pixel_address <= emit_addr_ff;
         rsp_item.pixel_value   <= (kind_ff == sopg_pkg::KIND_CLEAR) ? '0 : color_ff;
         rsp_item.off_screen    <= emit_off_ff;
         rsp_item.last_pixel    <= emit_last_ff;
      end
   end

   assign sts.yield      = yield;
   assign sts.fin        = fin;
   assign sts.need_root  = need_root;
   assign sts.root_last  = (rcnt_ff == '0);
   assign sts.pend_valid = pend_valid_ff;

endmodule

FILE: design/shape_outline_pixel_generator.sv
// Framebuffer write sequencer. A start item loads a shape, squares its extent
// and searches for its first write; it returns no result. Each tick item
// returns the next write of the shape with last_pixel on the final one, after
// the loop steps that search for the write behind it, and waits while an
// earlier result is still held; a circle column first computes its integer
// square root, found one digit per cycle. A tick after the shape has ended
// is accepted and returns nothing. One item is in progress at a time.
module shape_outline_pixel_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sopg_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sopg_pkg::rsp_type rsp_item
);

   sopg_pkg::cmd_type cmd;
   sopg_pkg::sts_type sts;

   sopg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_item.operation),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sopg_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

FILE: design/sopg_checker.sv
module sopg_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sopg_pkg::rsp_type rsp_item
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.off_screen |-> rsp_item.pixel_address == '0)
      else $error("off-screen item with nonzero address");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.pixel_address < 19'(sopg_pkg::SCREEN_PIXELS))
      else $error("address beyond the screen");

endmodule

bind shape_outline_pixel_generator sopg_checker u_sopg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
